// ===== src/gim_pkg.sv =====
// Shared types, widths and helpers for the grid index mapper.
`default_nettype none
package gim_pkg;

	localparam int MAX_EXTENT = 1024;
	localparam int COORD_BITS = 16;
	localparam int EXT_W      = $clog2(MAX_EXTENT + 1);
	localparam int CRD_W      = $clog2(MAX_EXTENT);
	localparam int LIN_W      = 30;
	localparam int T_W        = CRD_W + EXT_W;
	localparam int DIV_BITS   = 8;
	localparam int DIV_ST     = (LIN_W + DIV_BITS - 1) / DIV_BITS;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_W       = ((MODE_W + 3 * COORD_BITS + LIN_W + 7) / 8) * 8;
	localparam int OUT_W      = ((LIN_W + 2 * CRD_W + LIN_W + 1 + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		M_PT_LIN   = 3'd0,
		M_PT_SPLIT = 3'd1,
		M_CL_LIN   = 3'd2,
		M_CL_SPLIT = 3'd3,
		M_SN_CRD   = 3'd4,
		M_SN_IDX   = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXT_X = 2'd0,
		REG_EXT_Y = 2'd1,
		REG_EXT_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [EXT_W-1:0] x;
		logic [EXT_W-1:0] y;
		logic [EXT_W-1:0] z;
	} ext_t;

	typedef struct packed {
		mode_t                 mode;
		logic                  err;
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic [COORD_BITS-1:0] az;
		logic [2:0]            ng;
		logic                  py;
		logic                  pz;
		logic [CRD_W-1:0]      r1;
		logic [CRD_W-1:0]      r2;
		logic [LIN_W-1:0]      q2;
	} pl_t;

	typedef struct packed {
		logic             err;
		logic [LIN_W-1:0] z;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] x;
		logic [LIN_W-1:0] linear;
	} res_t;

	function automatic logic is_cell(input mode_t m);
		return (m == M_CL_LIN) || (m == M_CL_SPLIT);
	endfunction

	// cell modes divide by extent minus one
	function automatic logic [EXT_W-1:0] eff_ext(input logic [EXT_W-1:0] e, input logic cl);
		return cl ? e - EXT_W'(1) : e;
	endfunction

endpackage
`default_nettype wire

// ===== src/gim_div.sv =====
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
`default_nettype none
module gim_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_vld,
	input  wire logic [gim_pkg::LIN_W-1:0]  dividend,
	input  wire logic [gim_pkg::EXT_W-1:0]  divisor,
	input  wire gim_pkg::pl_t               side_in,
	output logic                            out_vld,
	output logic [gim_pkg::LIN_W-1:0]       quo,
	output logic [gim_pkg::EXT_W-1:0]       rem,
	output gim_pkg::pl_t                    side_out
);

	logic                      vld_s  [gim_pkg::DIV_ST+1];
	logic [gim_pkg::LIN_W-1:0] dq_s   [gim_pkg::DIV_ST+1];
	logic [gim_pkg::EXT_W-1:0] r_s    [gim_pkg::DIV_ST+1];
	logic [gim_pkg::EXT_W-1:0] d_s    [gim_pkg::DIV_ST+1];
	gim_pkg::pl_t              side_s [gim_pkg::DIV_ST+1];

	assign vld_s[0]  = in_vld;
	assign dq_s[0]   = dividend;
	assign r_s[0]    = '0;
	assign d_s[0]    = divisor;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < gim_pkg::DIV_ST; g++) begin : g_st
		logic [gim_pkg::LIN_W-1:0] dq_n;
		logic [gim_pkg::EXT_W-1:0] r_n;

		always_comb begin
			logic [gim_pkg::EXT_W:0] rw;
			dq_n = dq_s[g];
			r_n  = r_s[g];
			rw   = '0;
			for (int k = 0; k < gim_pkg::DIV_BITS; k++) begin
				if (g * gim_pkg::DIV_BITS + k < gim_pkg::LIN_W) begin
					rw   = {r_n, dq_n[gim_pkg::LIN_W-1]};
					dq_n = {dq_n[gim_pkg::LIN_W-2:0], 1'b0};
					if (rw >= {1'b0, d_s[g]}) begin
						rw      = rw - {1'b0, d_s[g]};
						dq_n[0] = 1'b1;
					end
					r_n = rw[gim_pkg::EXT_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[g+1]   <= dq_n;
				r_s[g+1]    <= r_n;
				d_s[g+1]    <= d_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[gim_pkg::DIV_ST];
	assign quo      = dq_s[gim_pkg::DIV_ST];
	assign rem      = r_s[gim_pkg::DIV_ST];
	assign side_out = side_s[gim_pkg::DIV_ST];

endmodule
`default_nettype wire

// ===== src/gim_lin.sv =====
// Wrap fix-up, serpentine mirroring and two-stage linearisation.
`default_nettype none
module gim_lin (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire gim_pkg::pl_t              pl,
	input  wire logic [gim_pkg::CRD_W-1:0] r3,
	input  wire gim_pkg::ext_t             ext,
	output logic                           out_vld,
	output gim_pkg::res_t                  res
);

	logic                      cl_mode, sn, split, lin_on, pyb, pzb;
	logic [gim_pkg::EXT_W-1:0] nx, ny, nz, xm, ym, zm, mx, my;
	logic [gim_pkg::CRD_W-1:0] fx, fy, fz;
	gim_pkg::res_t             part;

	logic                      vld_s1, vld_s2, vld_s3;
	logic                      on_s1, on_s2;
	logic [gim_pkg::CRD_W-1:0] x_s1, y_s1, z_s1, x_s2;
	logic [gim_pkg::EXT_W-1:0] nx_s1, ny_s1, nx_s2;
	logic [gim_pkg::T_W-1:0]   t_s2;
	gim_pkg::res_t             res_s1, res_s2, res_s3, fin;
	logic [gim_pkg::T_W+gim_pkg::EXT_W-1:0] prod;

	always_comb begin
		cl_mode = gim_pkg::is_cell(pl.mode);
		nx    = gim_pkg::eff_ext(ext.x, cl_mode);
		ny    = gim_pkg::eff_ext(ext.y, cl_mode);
		nz    = gim_pkg::eff_ext(ext.z, cl_mode);
		sn    = (pl.mode == gim_pkg::M_SN_CRD) || (pl.mode == gim_pkg::M_SN_IDX);
		split = (pl.mode == gim_pkg::M_PT_SPLIT) || (pl.mode == gim_pkg::M_CL_SPLIT);
		lin_on = !pl.err && ((pl.mode == gim_pkg::M_PT_LIN) || (pl.mode == gim_pkg::M_CL_LIN)
			|| sn);
		// floor modulo: a negative coordinate with a nonzero remainder folds to n - r
		xm = (pl.ng[0] && pl.r1 != '0) ? nx - gim_pkg::EXT_W'(pl.r1) : gim_pkg::EXT_W'(pl.r1);
		ym = (pl.ng[1] && pl.r2 != '0) ? ny - gim_pkg::EXT_W'(pl.r2) : gim_pkg::EXT_W'(pl.r2);
		zm = (pl.ng[2] && r3 != '0) ? nz - gim_pkg::EXT_W'(r3) : gim_pkg::EXT_W'(r3);
		mx = nx - gim_pkg::EXT_W'(1) - xm;
		my = ny - gim_pkg::EXT_W'(1) - ym;
		pyb = (pl.mode == gim_pkg::M_SN_IDX) ? pl.r2[0] : pl.py;
		pzb = (pl.mode == gim_pkg::M_SN_IDX) ? pl.q2[0] : pl.pz;
		fx = xm[gim_pkg::CRD_W-1:0];
		fy = ym[gim_pkg::CRD_W-1:0];
		fz = zm[gim_pkg::CRD_W-1:0];
		if (sn) begin
			if (!pzb) begin
				if (pyb) fx = mx[gim_pkg::CRD_W-1:0];
			end else begin
				fy = my[gim_pkg::CRD_W-1:0];
				if (!(ny[0] ^ pyb)) fx = mx[gim_pkg::CRD_W-1:0];
			end
		end
		part        = '0;
		part.err    = pl.err;
		if (split && !pl.err) begin
			part.x = pl.r1;
			part.y = pl.r2;
			part.z = pl.q2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign prod = t_s2 * nx_s2;

	always_comb begin
		fin        = res_s2;
		fin.linear = on_s2 ? gim_pkg::LIN_W'(prod + gim_pkg::T_W'(x_s2)) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= fx;
			y_s1   <= fy;
			z_s1   <= fz;
			nx_s1  <= nx;
			ny_s1  <= ny;
			on_s1  <= lin_on;
			res_s1 <= part;

			t_s2   <= gim_pkg::T_W'(z_s1) * gim_pkg::T_W'(ny_s1) + gim_pkg::T_W'(y_s1);
			x_s2   <= x_s1;
			nx_s2  <= nx_s1;
			on_s2  <= on_s1;
			res_s2 <= res_s1;

			res_s3 <= fin;
		end
	end

	assign out_vld = vld_s3;
	assign res     = res_s3;

endmodule
`default_nettype wire

// ===== src/grid_index_mapper.sv =====
// Top level of the grid index mapper: config registers, input stage and pipeline.
//
//  group   direction  handshake          payload
//  s_*     in         s_tvalid/s_tready  s_tdata  item words
//  m_*     out        m_tvalid/m_tready  m_tdata  result words
//  cfg_*   in         cfg_valid/ready    cfg_index, cfg_data extent writes
//
// One word enters per cycle while the pipeline is not held; each word passes an input
// register and the three chained pipelined dividers of DIV_BITS bits per stage.
// The whole pipeline holds when the output word is waiting and m_tready is low.
// Reset clears every valid bit; extents reset to one.
`default_nettype none
module grid_index_mapper (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// mode[2:0], coord_x[18:3], coord_y[34:19], coord_z[50:35], linear_in[80:51]
	input  wire logic [gim_pkg::IN_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// linear_out[29:0], out_x[39:30], out_y[49:40], out_z[79:50], div_error[80]
	output logic [gim_pkg::OUT_W-1:0]           m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [gim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gim_pkg::EXT_W-1:0]      cfg_data
);

	localparam int CB = gim_pkg::COORD_BITS;
	localparam int MB = gim_pkg::MODE_W;

	gim_pkg::ext_t             ext_q;
	logic [gim_pkg::EXT_W-1:0] wval;
	logic                      en;

	gim_pkg::mode_t            mode;
	logic signed [CB-1:0]      cx, cy, cz;
	logic                      crd, spl;
	logic                      zx, zy, zz, ox, oy, oz;
	gim_pkg::pl_t              pl_in;

	logic                      vld_s1;
	gim_pkg::pl_t              pl_s1;
	logic [gim_pkg::LIN_W-1:0] idx_s1;

	logic                      v1, v2, v3, vo;
	logic [gim_pkg::LIN_W-1:0] q1, q2, q3, dd1, dd2, dd3;
	logic [gim_pkg::EXT_W-1:0] rm1, rm2, rm3;
	gim_pkg::pl_t              p1, p2, p3, p1f, p2f;
	gim_pkg::res_t             res;

	assign cfg_ready = 1'b1;
	assign wval = (cfg_data > gim_pkg::EXT_W'(gim_pkg::MAX_EXTENT))
		? gim_pkg::EXT_W'(gim_pkg::MAX_EXTENT) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= '{x: gim_pkg::EXT_W'(1), y: gim_pkg::EXT_W'(1), z: gim_pkg::EXT_W'(1)};
		end else if (cfg_valid) begin
			case (gim_pkg::cfg_reg_t'(cfg_index))
				gim_pkg::REG_EXT_X: ext_q.x <= wval;
				gim_pkg::REG_EXT_Y: ext_q.y <= wval;
				gim_pkg::REG_EXT_Z: ext_q.z <= wval;
				default: ;
			endcase
		end
	end

	// hold the whole pipeline while a finished word waits
	assign en       = !vo || m_tready;
	assign s_tready = en;

	always_comb begin
		mode = gim_pkg::mode_t'(s_tdata[MB-1:0]);
		cx   = s_tdata[MB+CB-1:MB];
		cy   = s_tdata[MB+2*CB-1:MB+CB];
		cz   = s_tdata[MB+3*CB-1:MB+2*CB];
		crd  = (mode == gim_pkg::M_PT_LIN) || (mode == gim_pkg::M_CL_LIN)
			|| (mode == gim_pkg::M_SN_CRD);
		zx = ext_q.x == '0;
		zy = ext_q.y == '0;
		zz = ext_q.z == '0;
		ox = ext_q.x <= gim_pkg::EXT_W'(1);
		oy = ext_q.y <= gim_pkg::EXT_W'(1);
		oz = ext_q.z <= gim_pkg::EXT_W'(1);
		pl_in      = '0;
		pl_in.mode = mode;
		pl_in.ax   = cx[CB-1] ? CB'(-cx) : CB'(cx);
		pl_in.ay   = cy[CB-1] ? CB'(-cy) : CB'(cy);
		pl_in.az   = cz[CB-1] ? CB'(-cz) : CB'(cz);
		pl_in.ng   = crd ? {cz[CB-1], cy[CB-1], cx[CB-1]} : 3'b000;
		pl_in.py   = cy[0];
		pl_in.pz   = cz[0];
		case (mode)
			gim_pkg::M_PT_LIN, gim_pkg::M_SN_CRD, gim_pkg::M_SN_IDX: pl_in.err = zx | zy | zz;
			gim_pkg::M_PT_SPLIT: pl_in.err = zx | zy;
			gim_pkg::M_CL_LIN:   pl_in.err = ox | oy | oz;
			gim_pkg::M_CL_SPLIT: pl_in.err = ox | oy;
			default:             pl_in.err = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= pl_in;
			idx_s1 <= s_tdata[MB+3*CB+gim_pkg::LIN_W-1:MB+3*CB];
		end
	end

	assign spl = (pl_s1.mode == gim_pkg::M_PT_SPLIT) || (pl_s1.mode == gim_pkg::M_CL_SPLIT)
		|| (pl_s1.mode == gim_pkg::M_SN_IDX);
	assign dd1 = spl ? idx_s1 : gim_pkg::LIN_W'(pl_s1.ax);

	gim_div u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.dividend(dd1),
		.divisor(gim_pkg::eff_ext(ext_q.x, gim_pkg::is_cell(pl_s1.mode))),
		.side_in(pl_s1),
		.out_vld(v1), .quo(q1), .rem(rm1), .side_out(p1)
	);

	always_comb begin
		p1f    = p1;
		p1f.r1 = rm1[gim_pkg::CRD_W-1:0];
		dd2    = ((p1.mode == gim_pkg::M_PT_SPLIT) || (p1.mode == gim_pkg::M_CL_SPLIT)
			|| (p1.mode == gim_pkg::M_SN_IDX)) ? q1 : gim_pkg::LIN_W'(p1.ay);
	end

	gim_div u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v1),
		.dividend(dd2),
		.divisor(gim_pkg::eff_ext(ext_q.y, gim_pkg::is_cell(p1.mode))),
		.side_in(p1f),
		.out_vld(v2), .quo(q2), .rem(rm2), .side_out(p2)
	);

	always_comb begin
		p2f    = p2;
		p2f.r2 = rm2[gim_pkg::CRD_W-1:0];
		p2f.q2 = q2;
		dd3    = (p2.mode == gim_pkg::M_SN_IDX) ? q2 : gim_pkg::LIN_W'(p2.az);
	end

	gim_div u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v2),
		.dividend(dd3),
		.divisor(gim_pkg::eff_ext(ext_q.z, gim_pkg::is_cell(p2.mode))),
		.side_in(p2f),
		.out_vld(v3), .quo(q3), .rem(rm3), .side_out(p3)
	);

	gim_lin u_lin (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v3 && (q3 == q3)),
		.pl(p3), .r3(rm3[gim_pkg::CRD_W-1:0]), .ext(ext_q),
		.out_vld(vo), .res(res)
	);

	assign m_tvalid = vo;
	assign m_tdata  = gim_pkg::OUT_W'(res);

endmodule
`default_nettype wire
